// ----- sv/chmi_pkg.sv -----
// ============================================================================
// chmi_pkg
// Shared constants, control word layout, microcode ROM and helpers for the
// cubic Hermite motion interpolator.
// ============================================================================
package chmi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 128;

    // multiplier: unsigned 17-bit fraction or 16-bit step length against a
    // signed operand of up to 35 bits
    localparam int OPA_W  = 18;
    localparam int OPB_W  = 35;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam int PC_W = 5;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    localparam logic AX_X = 1'b0;
    localparam logic AX_Y = 1'b1;

    localparam logic A_DT   = 1'b0;
    localparam logic A_FRAC = 1'b1;

    localparam logic [2:0] B_C3   = 3'd0;
    localparam logic [2:0] B_C3X3 = 3'd1;
    localparam logic [2:0] B_T0   = 3'd2;
    localparam logic [2:0] B_T1   = 3'd3;
    localparam logic [2:0] B_V    = 3'd4;
    localparam logic [2:0] B_W    = 3'd5;
    localparam logic [2:0] B_OV   = 3'd6;

    localparam logic [2:0] K_ZERO = 3'd0;
    localparam logic [2:0] K_C0   = 3'd1;
    localparam logic [2:0] K_C1   = 3'd2;
    localparam logic [2:0] K_C2   = 3'd3;
    localparam logic [2:0] K_C2X2 = 3'd4;
    localparam logic [2:0] K_DXM2 = 3'd5;
    localparam logic [2:0] K_DX3  = 3'd6;

    localparam logic [2:0] DST_T0  = 3'd0;
    localparam logic [2:0] DST_T1  = 3'd1;
    localparam logic [2:0] DST_POS = 3'd2;
    localparam logic [2:0] DST_VEL = 3'd3;
    localparam logic [2:0] DST_C1  = 3'd4;
    localparam logic [2:0] DST_C2  = 3'd5;
    localparam logic [2:0] DST_C3  = 3'd6;

    localparam logic [PC_W-1:0] ENTRY_NOP    = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_BEGIN  = 5'd1;
    localparam logic [PC_W-1:0] ENTRY_END    = 5'd2;
    localparam logic [PC_W-1:0] ENTRY_UPDATE = 5'd9;

    typedef struct packed {
        logic       last;
        logic       snap_load;
        logic       c0_copy;
        logic       iss_en;
        logic       iss_ax;
        logic       a_sel;
        logic [2:0] b_sel;
        logic       wb_en;
        logic       wb_ax;
        logic [2:0] wb_dst;
        logic [2:0] k_sel;
        logic       wb_neg;
    } ucode_t;

    function automatic ucode_t op_iss(input logic ax, input logic a, input logic [2:0] b);
        ucode_t w;
        w        = '0;
        w.iss_en = 1'b1;
        w.iss_ax = ax;
        w.a_sel  = a;
        w.b_sel  = b;
        return w;
    endfunction

    function automatic ucode_t op_wb(input logic ax, input logic [2:0] dst,
                                     input logic [2:0] k, input logic neg);
        ucode_t w;
        w        = '0;
        w.wb_en  = 1'b1;
        w.wb_ax  = ax;
        w.wb_dst = dst;
        w.k_sel  = k;
        w.wb_neg = neg;
        return w;
    endfunction

    // Each step writes back the product issued by the previous step and issues
    // the next multiply; the two axes alternate so dependent terms have a gap.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        w = '0;
        case (addr)
            5'd0: begin
                w.last = 1'b1;
            end
            5'd1: begin
                w.snap_load = 1'b1;
                w.last      = 1'b1;
            end
            // end of step: c3, c2, c1 per axis, then c0
            5'd2:  w = op_iss(AX_X, A_DT, B_V);
            5'd3:  w = op_wb(AX_X, DST_C3, K_DXM2, 1'b0) | op_iss(AX_Y, A_DT, B_V);
            5'd4:  w = op_wb(AX_Y, DST_C3, K_DXM2, 1'b0) | op_iss(AX_X, A_DT, B_W);
            5'd5:  w = op_wb(AX_X, DST_C2, K_DX3, 1'b1) | op_iss(AX_Y, A_DT, B_W);
            5'd6:  w = op_wb(AX_Y, DST_C2, K_DX3, 1'b1) | op_iss(AX_X, A_DT, B_OV);
            5'd7:  w = op_wb(AX_X, DST_C1, K_ZERO, 1'b0) | op_iss(AX_Y, A_DT, B_OV);
            5'd8: begin
                w         = op_wb(AX_Y, DST_C1, K_ZERO, 1'b0);
                w.c0_copy = 1'b1;
                w.last    = 1'b1;
            end
            // update: Horner for position and derivative
            5'd9:  w = op_iss(AX_X, A_FRAC, B_C3);
            5'd10: w = op_wb(AX_X, DST_T0, K_C2, 1'b0) | op_iss(AX_Y, A_FRAC, B_C3);
            5'd11: w = op_wb(AX_Y, DST_T0, K_C2, 1'b0) | op_iss(AX_X, A_FRAC, B_C3X3);
            5'd12: w = op_wb(AX_X, DST_T1, K_C2X2, 1'b0) | op_iss(AX_Y, A_FRAC, B_C3X3);
            5'd13: w = op_wb(AX_Y, DST_T1, K_C2X2, 1'b0) | op_iss(AX_X, A_FRAC, B_T0);
            5'd14: w = op_wb(AX_X, DST_T0, K_C1, 1'b0) | op_iss(AX_Y, A_FRAC, B_T0);
            5'd15: w = op_wb(AX_Y, DST_T0, K_C1, 1'b0) | op_iss(AX_X, A_FRAC, B_T1);
            5'd16: w = op_wb(AX_X, DST_VEL, K_C1, 1'b0) | op_iss(AX_Y, A_FRAC, B_T1);
            5'd17: w = op_wb(AX_Y, DST_VEL, K_C1, 1'b0) | op_iss(AX_X, A_FRAC, B_T0);
            5'd18: w = op_wb(AX_X, DST_POS, K_C0, 1'b0) | op_iss(AX_Y, A_FRAC, B_T0);
            5'd19: begin
                w      = op_wb(AX_Y, DST_POS, K_C0, 1'b0);
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    // dispatch on the item kind
    function automatic logic [PC_W-1:0] ucode_entry(input logic [1:0] mode,
                                                    input logic is_static);
        logic [PC_W-1:0] pc;
        pc = ENTRY_NOP;
        if (!is_static) begin
            case (mode)
                MODE_BEGIN:  pc = ENTRY_BEGIN;
                MODE_END:    pc = ENTRY_END;
                MODE_UPDATE: pc = ENTRY_UPDATE;
                default:     pc = ENTRY_NOP;
            endcase
        end
        return pc;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-32:0] hi;
        hi = x[SUM_W-1:31];
        if (&hi || ~|hi) begin
            return x[31:0];
        end else if (x[SUM_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7fff_ffff;
        end
    endfunction

endpackage

// ----- sv/cubic_hermite_motion_interpolator_top.sv -----
// ============================================================================
// cubic_hermite_motion_interpolator_top
// Two-axis cubic Hermite motion interpolator, Q16.16, run by a microcode ROM.
// ============================================================================
// One item is in work at a time and every item returns one result, the
// snapshot as it stands after the item. From acceptance to the next possible
// acceptance an item runs its microprogram and then the report step. The begin
// and no-op (static or unused-mode) programs are shortest, update the longest.
// Lengths follow from the single shared multiplier: each step issues one
// multiply and writes back the previous one, and the two axes alternate so
// each dependent Horner term is issued after its input is written back. A
// finished result waits in the output register while the next item is taken.
module cubic_hermite_motion_interpolator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, step_length[143:128], fraction[160:144], zero pad
    input  logic [chmi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0], is_static[2]
    input  logic [chmi_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y
    output logic [chmi_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam logic signed [chmi_pkg::SUM_W-1:0] RND_HALF =
        chmi_pkg::SUM_W'(64'sd1 <<< (chmi_pkg::FRAC_BITS - 1));

    logic                          busy_reg, busy_next;
    logic                          report_reg, report_next;
    logic                          m_valid_reg, m_valid_next;
    logic [chmi_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [chmi_pkg::M_TDATA_W-1:0] m_data_reg;

    logic                          s_accept;
    logic                          out_load;
    chmi_pkg::ucode_t              uc;

    // latched item
    logic signed [31:0]            pos_in_reg [2];
    logic signed [31:0]            vel_in_reg [2];
    logic [15:0]                   dt_reg;
    logic [16:0]                   frac_reg;

    // state
    logic signed [31:0]            snap_pos_reg [2];
    logic signed [31:0]            snap_vel_reg [2];
    logic signed [31:0]            c0_reg [2];
    logic signed [31:0]            c1_reg [2];
    logic signed [31:0]            c2_reg [2];
    logic signed [31:0]            c3_reg [2];
    logic signed [31:0]            t0_reg [2];
    logic signed [31:0]            t1_reg [2];

    // datapath
    logic signed [32:0]            dx [2];
    logic signed [32:0]            v_sum [2];
    logic signed [33:0]            w_sum [2];
    logic [chmi_pkg::OPA_W-1:0]    opa;
    logic signed [chmi_pkg::OPB_W-1:0] opb;
    logic signed [chmi_pkg::OPB_W-1:0] c3_ext;
    logic signed [chmi_pkg::PROD_W-1:0] prod_reg;
    logic signed [chmi_pkg::SUM_W-1:0]  prod_ext, prod_rnd, term, kval, sum;
    logic signed [chmi_pkg::SUM_W-1:0]  dx_ext, c2_ext;
    logic [31:0]                   wb_val;

    assign s_axis_tready = !busy_reg && !report_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = report_reg && (!m_valid_reg || m_axis_tready);
    assign uc            = chmi_pkg::ucode_rom(pc_reg);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // sequencer
    always_comb begin
        busy_next    = busy_reg;
        report_next  = report_reg;
        m_valid_next = m_valid_reg;
        pc_next      = pc_reg;
        if (s_accept) begin
            busy_next = 1'b1;
            pc_next   = chmi_pkg::ucode_entry(s_axis_tuser[1:0], s_axis_tuser[2]);
        end else if (busy_reg) begin
            if (uc.last) begin
                busy_next   = 1'b0;
                report_next = 1'b1;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
        if (out_load) begin
            report_next  = 1'b0;
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            report_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            busy_reg    <= busy_next;
            report_reg  <= report_next;
            m_valid_reg <= m_valid_next;
            pc_reg      <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {snap_vel_reg[1], snap_vel_reg[0], snap_pos_reg[1], snap_pos_reg[0]};
        end
    end

    // hold the item for the whole program
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pos_in_reg[0] <= s_axis_tdata[31:0];
            pos_in_reg[1] <= s_axis_tdata[63:32];
            vel_in_reg[0] <= s_axis_tdata[95:64];
            vel_in_reg[1] <= s_axis_tdata[127:96];
            dt_reg        <= s_axis_tdata[143:128];
            frac_reg      <= s_axis_tdata[160:144];
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            dx[i]    = 33'(pos_in_reg[i]) - 33'(snap_pos_reg[i]);
            v_sum[i] = 33'(vel_in_reg[i]) + 33'(snap_vel_reg[i]);
            w_sum[i] = 34'(v_sum[i]) + 34'(snap_vel_reg[i]);
        end
    end

    // multiplier operands
    always_comb begin
        c3_ext = chmi_pkg::OPB_W'(c3_reg[uc.iss_ax]);
        opa    = (uc.a_sel == chmi_pkg::A_FRAC) ? {1'b0, frac_reg} : {2'b00, dt_reg};
        case (uc.b_sel)
            chmi_pkg::B_C3:   opb = c3_ext;
            chmi_pkg::B_C3X3: opb = (c3_ext <<< 1) + c3_ext;
            chmi_pkg::B_T0:   opb = chmi_pkg::OPB_W'(t0_reg[uc.iss_ax]);
            chmi_pkg::B_T1:   opb = chmi_pkg::OPB_W'(t1_reg[uc.iss_ax]);
            chmi_pkg::B_V:    opb = chmi_pkg::OPB_W'(v_sum[uc.iss_ax]);
            chmi_pkg::B_W:    opb = chmi_pkg::OPB_W'(w_sum[uc.iss_ax]);
            chmi_pkg::B_OV:   opb = chmi_pkg::OPB_W'(snap_vel_reg[uc.iss_ax]);
            default:          opb = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && uc.iss_en) begin
            prod_reg <= $signed(opa) * opb;
        end
    end

    // round, add the selected term, saturate
    always_comb begin
        prod_ext = chmi_pkg::SUM_W'(prod_reg);
        prod_rnd = (prod_ext + RND_HALF) >>> chmi_pkg::FRAC_BITS;
        term     = uc.wb_neg ? -prod_rnd : prod_rnd;
        dx_ext   = chmi_pkg::SUM_W'(dx[uc.wb_ax]);
        c2_ext   = chmi_pkg::SUM_W'(c2_reg[uc.wb_ax]);
        case (uc.k_sel)
            chmi_pkg::K_ZERO: kval = '0;
            chmi_pkg::K_C0:   kval = chmi_pkg::SUM_W'(c0_reg[uc.wb_ax]);
            chmi_pkg::K_C1:   kval = chmi_pkg::SUM_W'(c1_reg[uc.wb_ax]);
            chmi_pkg::K_C2:   kval = c2_ext;
            chmi_pkg::K_C2X2: kval = c2_ext <<< 1;
            chmi_pkg::K_DXM2: kval = -(dx_ext <<< 1);
            chmi_pkg::K_DX3:  kval = (dx_ext <<< 1) + dx_ext;
            default:          kval = '0;
        endcase
        sum    = term + kval;
        wb_val = chmi_pkg::sat32(sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                snap_pos_reg[i] <= '0;
                snap_vel_reg[i] <= '0;
                c0_reg[i]       <= '0;
                c1_reg[i]       <= '0;
                c2_reg[i]       <= '0;
                c3_reg[i]       <= '0;
            end
        end else if (busy_reg) begin
            if (uc.snap_load) begin
                snap_pos_reg <= pos_in_reg;
                snap_vel_reg <= vel_in_reg;
            end
            if (uc.c0_copy) begin
                c0_reg <= snap_pos_reg;
            end
            if (uc.wb_en) begin
                case (uc.wb_dst)
                    chmi_pkg::DST_POS: snap_pos_reg[uc.wb_ax] <= wb_val;
                    chmi_pkg::DST_VEL: snap_vel_reg[uc.wb_ax] <= wb_val;
                    chmi_pkg::DST_C1:  c1_reg[uc.wb_ax]       <= wb_val;
                    chmi_pkg::DST_C2:  c2_reg[uc.wb_ax]       <= wb_val;
                    chmi_pkg::DST_C3:  c3_reg[uc.wb_ax]       <= wb_val;
                    default: ;
                endcase
            end
        end
    end

    // Horner temporaries: a then b in t0, derivative term in t1
    always_ff @(posedge aclk) begin
        if (busy_reg && uc.wb_en) begin
            case (uc.wb_dst)
                chmi_pkg::DST_T0: t0_reg[uc.wb_ax] <= wb_val;
                chmi_pkg::DST_T1: t1_reg[uc.wb_ax] <= wb_val;
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/chmi_checker.sv -----
// ============================================================================
// chmi_checker
// Port-level checks for the cubic Hermite motion interpolator.
// ============================================================================
module chmi_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [chmi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [chmi_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [chmi_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    logic s_accept;
    logic unused_in;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign unused_in = ^{s_axis_tdata, s_axis_tuser};

    // an accepted transaction blocks the input at least through the work and report cycles of the shortest program
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready too soon after a transaction");

    // a result only appears for an item that blocked the input
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_axis_tvalid) && $past(aresetn)) |-> $past(!s_axis_tready))
        else $error("result raised without an item in work");

    // input reopens only once its result is posted
    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(s_axis_tready) && $past(aresetn)) |-> m_axis_tvalid)
        else $error("input reopened without a posted result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind cubic_hermite_motion_interpolator_top chmi_checker u_chmi_checker (.*);
